// ----- sv/utf8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types, widths and lead byte decode for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CP_W    = 31;
  localparam int unsigned REM_W   = 3;

  localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = '1;

  typedef enum logic [1:0] {
    KIND_CODE  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    kind_t              kind;
    logic               stream_end;
    logic [COUNT_W-1:0] char_count;
  } result_t;

  typedef struct packed {
    logic             stopped;
    logic [REM_W-1:0] bytes_remaining;
  } seq_status_t;

  typedef struct packed {
    logic             invalid;
    logic [REM_W-1:0] follow;
    logic [6:0]       payload;
  } lead_t;

  // sequence length and payload bits of a lead byte
  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t l;
    l.invalid = 1'b0;
    l.follow  = '0;
    l.payload = '0;
    if (b <= 8'h7f) begin
      l.payload = b[6:0];
    end else if (b <= 8'hdf) begin
      l.follow  = 3'd1;
      l.payload = {2'b00, b[4:0]};
    end else if (b <= 8'hef) begin
      l.follow  = 3'd2;
      l.payload = {3'b000, b[3:0]};
    end else if (b <= 8'hf7) begin
      l.follow  = 3'd3;
      l.payload = {4'b0000, b[2:0]};
    end else if (b <= 8'hfb) begin
      l.follow  = 3'd4;
      l.payload = {5'b00000, b[1:0]};
    end else if (b <= 8'hfd) begin
      l.follow  = 3'd5;
      l.payload = {6'b000000, b[0]};
    end else begin
      l.invalid = 1'b1;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- sv/utf8sd_in_stage.sv -----
// ----------------------------------------------------------------------------
// utf8sd_in_stage
// Input register: holds one byte and its last flag until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_byte,
  output logic            held_last
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8sd_core.sv -----
// ----------------------------------------------------------------------------
// utf8sd_core
// Sequence state and the per-byte decode step: gathers payload bits, counts
// code points and flags errors, stop and end of stream.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             last_byte,
  input  wire logic [utf8sd_pkg::COUNT_W-1:0]   max_chars,
  output logic                                  has_result,
  output utf8sd_pkg::result_t                   result,
  output utf8sd_pkg::seq_status_t               status
);

  logic [utf8sd_pkg::CP_W-1:0]    partial_value, partial_value_next;
  logic [utf8sd_pkg::REM_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [utf8sd_pkg::COUNT_W-1:0] chars_delivered, chars_delivered_next;
  logic                           stopped, stopped_next;

  utf8sd_pkg::lead_t              lead;
  logic                           discard;
  logic [utf8sd_pkg::CP_W-1:0]    pv_step;
  logic [utf8sd_pkg::REM_W-1:0]   rem_step;
  logic [utf8sd_pkg::COUNT_W-1:0] count_inc;

  assign lead      = utf8sd_pkg::lead_decode(data_byte);
  assign count_inc = chars_delivered + 1'b1;
  // capacity check only applies between sequences
  assign discard   = stopped || (bytes_remaining == '0 && chars_delivered >= max_chars);

  always_comb begin
    if (bytes_remaining == '0) begin
      pv_step  = {{(utf8sd_pkg::CP_W-7){1'b0}}, lead.payload};
      rem_step = lead.follow;
    end else begin
      pv_step  = {partial_value[utf8sd_pkg::CP_W-7:0], data_byte[5:0]};
      rem_step = bytes_remaining - 1'b1;
    end
  end

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    chars_delivered_next = chars_delivered;
    stopped_next         = stopped;
    has_result           = 1'b0;
    result.code_point    = '0;
    result.kind          = utf8sd_pkg::KIND_CODE;
    result.stream_end    = last_byte;
    result.char_count    = chars_delivered;

    if (discard) begin
      stopped_next = 1'b1;
      if (last_byte) begin
        has_result           = 1'b1;
        result.kind          = utf8sd_pkg::KIND_END;
        result.char_count    = '0;
        partial_value_next   = '0;
        bytes_remaining_next = '0;
        chars_delivered_next = '0;
        stopped_next         = 1'b0;
      end
    end else if (bytes_remaining == '0 && lead.invalid) begin
      has_result         = 1'b1;
      result.kind        = utf8sd_pkg::KIND_ERROR;
      partial_value_next = '0;
      stopped_next       = 1'b1;
      if (last_byte) begin
        bytes_remaining_next = '0;
        chars_delivered_next = '0;
        stopped_next         = 1'b0;
      end
    end else if (rem_step != '0) begin
      partial_value_next   = pv_step;
      bytes_remaining_next = rem_step;
      if (last_byte) begin
        // stream ends inside a sequence
        has_result           = 1'b1;
        result.kind          = utf8sd_pkg::KIND_ERROR;
        partial_value_next   = '0;
        bytes_remaining_next = '0;
        chars_delivered_next = '0;
      end
    end else begin
      has_result           = 1'b1;
      result.code_point    = pv_step;
      result.char_count    = count_inc;
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      if (last_byte) begin
        chars_delivered_next = '0;
      end else begin
        chars_delivered_next = count_inc;
        stopped_next         = count_inc >= max_chars;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= '0;
      chars_delivered <= '0;
      stopped         <= 1'b0;
    end else if (step) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      chars_delivered <= chars_delivered_next;
      stopped         <= stopped_next;
    end
  end

  assign status.stopped         = stopped;
  assign status.bytes_remaining = bytes_remaining;

endmodule

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with output capacity limit.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the input word channel and gives one result
// word per completed sequence, error, or end of stream. Each byte passes an
// input register, combinational decode logic, and an output register; its
// result word is loaded as the byte leaves the input register. The block
// sustains one byte per cycle as long as the output side takes results when
// they are offered. A byte that gives no result never waits on the output
// side. max_chars may only be written while the block is idle.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]         code_point,
  output logic [1:0]                          result_kind,
  output logic                                stream_end,
  output logic [utf8sd_pkg::COUNT_W-1:0]      char_count,
  input  wire logic                           cfg_wr_en,
  input  wire logic [utf8sd_pkg::COUNT_W-1:0] cfg_wr_data
);

  logic [utf8sd_pkg::COUNT_W-1:0] max_chars;
  logic                           held_valid;
  logic [7:0]                     held_byte;
  logic                           held_last;
  logic                           take;
  logic                           out_free;
  logic                           has_result;
  utf8sd_pkg::result_t            result;
  utf8sd_pkg::result_t            out_word;
  utf8sd_pkg::seq_status_t        status;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= utf8sd_pkg::MAX_CHARS_RESET;
    end else if (cfg_wr_en) begin
      max_chars <= cfg_wr_data;
    end
  end

  utf8sd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  utf8sd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (take),
    .data_byte  (held_byte),
    .last_byte  (held_last),
    .max_chars  (max_chars),
    .has_result (has_result),
    .result     (result),
    .status     (status)
  );

  assign out_free = !out_valid || out_ready;
  // bytes with no result advance even while the output word is stalled
  assign take     = held_valid && (out_free || !has_result);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      out_word <= result;
    end
  end

  assign code_point  = out_word.code_point;
  assign result_kind = out_word.kind;
  assign stream_end  = out_word.stream_end;
  assign char_count  = out_word.char_count;

  a_end_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == utf8sd_pkg::KIND_END |-> stream_end && char_count == '0)
    else $error("end-only word without stream end or with nonzero count");

  a_no_cp_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != utf8sd_pkg::KIND_CODE |-> code_point == '0)
    else $error("error or end word carries a code point");

  a_stop_between_seq: assert property (@(posedge clk) disable iff (rst)
    status.stopped |-> status.bytes_remaining == '0)
    else $error("stopped inside a sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(take && has_result))
    else $error("result loaded over a stalled output word");

endmodule

`default_nettype wire
